@@ rtl/rcht_pkg.sv @@
// ============================================================================
// rcht_pkg: shared types and constants of the ref-counted handle table
// Request and response payloads, request kinds, status codes, table sizes.
// ============================================================================
package rcht_pkg;

    localparam int HANDLE_COUNT = 256;
    localparam int VALUE_BITS   = 32;
    localparam int COUNT_BITS   = 16;

    localparam int HW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;

    localparam logic [HW:0]           HCOUNT = (HW + 1)'(HANDLE_COUNT);
    localparam logic [COUNT_BITS-1:0] CMAX   = '1;

    // request kinds
    localparam logic [2:0] KIND_SAVE  = 3'd0;
    localparam logic [2:0] KIND_ADD   = 3'd1;
    localparam logic [2:0] KIND_DROP  = 3'd2;
    localparam logic [2:0] KIND_QUERY = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  handle_in;
        logic [31:0] store_value;
    } t_req;

    typedef struct packed {
        logic [7:0]  handle_out;
        logic [15:0] ref_count;
        logic [31:0] read_value;
        logic        was_freed;
        logic [8:0]  live_items;
        logic [1:0]  status;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;   // latch the request
        logic read;   // read the tables
        logic exec;   // update tables, register the response
    } t_cmd;

endpackage

@@ rtl/rcht_ctrl.sv @@
// ============================================================================
// rcht_ctrl: request sequencer
// Steps each accepted request through table read and execute.
// ============================================================================
module rcht_ctrl
    import rcht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_READ;
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_cmd.load = i_start && (r_state == S_IDLE);
    assign o_cmd.read = (r_state == S_READ);
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

@@ rtl/rcht_dp.sv @@
// ============================================================================
// rcht_dp: handle table datapath
// Value, count and free-stack memories, allocation counters, response register.
// ============================================================================
module rcht_dp
    import rcht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    logic [VALUE_BITS-1:0] value_mem [HANDLE_COUNT];
    logic [COUNT_BITS-1:0] count_mem [HANDLE_COUNT];
    logic [HW-1:0]         stack_mem [HANDLE_COUNT];
    logic [HANDLE_COUNT-1:0] r_cvalid;   // count entry written since reset

    t_req                  r_req;
    logic [HW:0]           r_depth, n_depth;
    logic [HW:0]           r_fresh, n_fresh;
    logic [HW:0]           r_live,  n_live;

    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic                  r_vld_rd;
    logic [VALUE_BITS-1:0] r_val_rd;
    logic [HW-1:0]         r_stk_rd;

    logic                  r_done;
    t_rsp                  r_rsp, n_rsp;

    logic [HW-1:0]         idx;
    logic                  in_rng;
    logic                  live;
    logic                  got;
    logic [HW-1:0]         nh;
    logic                  cnt_we;
    logic [HW-1:0]         cnt_wa;
    logic [COUNT_BITS-1:0] cnt_wd;
    logic                  val_we;
    logic                  stk_we;

    assign idx    = HW'(r_req.handle_in);
    assign in_rng = ({1'b0, r_req.handle_in} < 9'(HANDLE_COUNT > 256 ? 256 : HANDLE_COUNT))
                    || (HANDLE_COUNT > 256);
    assign live   = in_rng && r_vld_rd && (r_cnt_rd != '0);

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
    end

    // registered table reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_cnt_rd <= count_mem[idx];
            r_val_rd <= value_mem[idx];
            r_stk_rd <= stack_mem[HW'(r_depth - 1'b1)];
            r_vld_rd <= r_cvalid[idx];
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (cnt_we) count_mem[cnt_wa] <= cnt_wd;
        if (val_we) value_mem[nh] <= VALUE_BITS'(r_req.store_value);
        if (stk_we) stack_mem[HW'(r_depth)] <= idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_depth  <= '0;
            r_fresh  <= '0;
            r_live   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (cnt_we) r_cvalid[cnt_wa] <= 1'b1;
            if (i_cmd.exec) begin
                r_depth <= n_depth;
                r_fresh <= n_fresh;
                r_live  <= n_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_rsp <= n_rsp;
    end

    always_comb begin
        n_depth = r_depth;
        n_fresh = r_fresh;
        n_live  = r_live;
        got     = 1'b0;
        nh      = '0;
        cnt_we  = 1'b0;
        cnt_wa  = idx;
        cnt_wd  = '0;
        val_we  = 1'b0;
        stk_we  = 1'b0;
        n_rsp   = '0;
        n_rsp.handle_out = r_req.handle_in;
        n_rsp.status     = ST_OK;

        unique case (r_req.kind)
            KIND_SAVE: begin
                if (r_depth != '0) begin
                    got     = 1'b1;
                    nh      = r_stk_rd;
                    n_depth = r_depth - 1'b1;
                end else if (r_fresh < HCOUNT) begin
                    got     = 1'b1;
                    nh      = HW'(r_fresh);
                    n_fresh = r_fresh + 1'b1;
                end
                if (got) begin
                    cnt_we = i_cmd.exec;
                    cnt_wa = nh;
                    cnt_wd = COUNT_BITS'(1);
                    val_we = i_cmd.exec;
                    n_live = r_live + 1'b1;
                    n_rsp.handle_out = 8'(nh);
                    n_rsp.ref_count  = 16'(1);
                end else begin
                    n_rsp.status = ST_FULL;
                end
            end
            KIND_ADD: begin
                if (!live) begin
                    n_rsp.status = ST_UNKNOWN;
                end else if (r_cnt_rd == CMAX) begin
                    n_rsp.ref_count = 16'(CMAX);
                    n_rsp.status    = ST_SAT;
                end else begin
                    cnt_we = i_cmd.exec;
                    cnt_wd = r_cnt_rd + 1'b1;
                    n_rsp.ref_count = 16'(cnt_wd);
                end
            end
            KIND_DROP: begin
                if (!live) begin
                    n_rsp.status = ST_UNKNOWN;
                end else begin
                    cnt_we = i_cmd.exec;
                    cnt_wd = r_cnt_rd - 1'b1;
                    n_rsp.ref_count = 16'(cnt_wd);
                    if (cnt_wd == '0) begin
                        // last reference gone: release the handle
                        if (r_depth < HCOUNT) begin
                            stk_we  = i_cmd.exec;
                            n_depth = r_depth + 1'b1;
                        end
                        if (r_live != '0) n_live = r_live - 1'b1;
                        n_rsp.was_freed = 1'b1;
                    end
                end
            end
            KIND_QUERY: begin
                if (!live) n_rsp.status    = ST_UNKNOWN;
                else       n_rsp.ref_count = 16'(r_cnt_rd);
            end
            KIND_READ: begin
                if (!live) begin
                    n_rsp.status = ST_UNKNOWN;
                end else begin
                    n_rsp.ref_count  = 16'(r_cnt_rd);
                    n_rsp.read_value = 32'(r_val_rd);
                end
            end
            default: ;  // unused kinds: echo only
        endcase

        n_rsp.live_items = 9'(n_live);
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ rtl/refcounted_handle_table.sv @@
// ============================================================================
// refcounted_handle_table: reference-counted handle allocator
// Stores values under handles and keeps a use count for each handle.
// ============================================================================
// Usage
//   Requests: drive i_req and raise start; the transfer happens at the rising
//   edge where start is high and busy is low. Kinds are save, add reference,
//   drop reference, query count and read value.
//   Responses: o_rsp is valid for exactly the one cycle in which o_done is
//   high; the receiver cannot hold it off, so it must take it then.
// Timing
//   The accepting edge is followed by a table read cycle and an execute
//   cycle; o_done is registered at the end of the execute cycle. busy is
//   high for the read and execute cycles and drops as the response appears,
//   so a new request can be transferred in that same cycle. Requests do
//   not overlap: each goes through the registered read of the count,
//   value and free-stack memories and then their write-back.
// Reset
//   Synchronous, active low. All handles become unallocated (count valid
//   bits cleared at once, no clearing pass), the free stack is emptied and
//   fresh handle numbering restarts at zero. No response is pending.
// ============================================================================
module refcounted_handle_table
    import rcht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    t_cmd cmd;

    // sequencer: idle -> read -> execute
    rcht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // tables, free stack, counters and response register
    rcht_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

@@ rtl/rcht_checker.sv @@
// ============================================================================
// rcht_checker: port-level checks for the handle table
// Watches the top-level ports; attached by bind.
// ============================================================================
module rcht_checker
    import rcht_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_rsp o_rsp
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("response strobe longer than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("response shown while busy");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_UNKNOWN) |->
            (o_rsp.ref_count == '0 && o_rsp.read_value == '0 && !o_rsp.was_freed))
        else $error("unknown handle response carries data");

    a_freed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.was_freed) |->
            (o_rsp.status == ST_OK && o_rsp.ref_count == '0))
        else $error("freed handle with nonzero count");

endmodule

bind refcounted_handle_table rcht_checker u_rcht_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
